// File: hw/rtl/lbfs_pkg.sv
// lbfs_pkg: shared types, codes and constant functions of the led breathe and flash sequencer
// holds the item and colour types, flash pattern tables and the sin squared envelope function
// no dependencies
`default_nettype none

package lbfs_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET_TARGET = 2'd1;
    localparam logic [1:0] OP_FLASH      = 2'd2;

    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_SOLID   = 2'd1;
    localparam logic [1:0] MODE_BREATHE = 2'd2;

    localparam logic [2:0] FLASH_TAG_SEEN    = 3'd0;
    localparam logic [2:0] FLASH_PARSE_FAIL  = 3'd1;
    localparam logic [2:0] FLASH_WRITE_OK    = 3'd2;
    localparam logic [2:0] FLASH_WRITE_FAIL  = 3'd3;
    localparam logic [2:0] FLASH_WARNING     = 3'd4;

    localparam logic [7:0] GRAY_LEVEL = 8'h33;
    localparam logic [7:0] FULL_LEVEL = 8'd255;
    localparam logic [7:0] AMBER_GREEN = 8'd180;

    localparam logic [2:0] LONG_PATTERN_PHASES  = 3'd6;
    localparam logic [2:0] SHORT_PATTERN_PHASES = 3'd1;
    localparam logic [3:0] TAG_PHASE_TICKS      = 4'd8;
    localparam logic [3:0] WARNING_PHASE_TICKS  = 4'd15;
    localparam logic [3:0] SINGLE_PHASE_TICKS   = 4'd10;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] target_mode;
        colour_t    colour;
        logic [2:0] flash_kind;
    } item_t;

    typedef struct packed {
        logic    busy;
        colour_t colour;
    } flash_view_t;

    function automatic logic [2:0] phase_count(input logic [2:0] kind);
        logic [2:0] count;
        if (kind == FLASH_TAG_SEEN || kind == FLASH_WARNING)
            count = LONG_PATTERN_PHASES;
        else
            count = SHORT_PATTERN_PHASES;
        return count;
    endfunction

    function automatic logic [3:0] phase_length(input logic [2:0] kind);
        logic [3:0] ticks;
        if (kind == FLASH_TAG_SEEN)
            ticks = TAG_PHASE_TICKS;
        else if (kind == FLASH_WARNING)
            ticks = WARNING_PHASE_TICKS;
        else
            ticks = SINGLE_PHASE_TICKS;
        return ticks;
    endfunction

    function automatic colour_t phase_colour(input logic [2:0] kind, input logic [2:0] phase);
        colour_t c;
        c = '0;
        if (!phase[0])
        begin
            case (kind)
                FLASH_TAG_SEEN: c = '{FULL_LEVEL, FULL_LEVEL, FULL_LEVEL};
                FLASH_WRITE_OK: c = '{8'd0, FULL_LEVEL, 8'd0};
                FLASH_WARNING:  c = '{FULL_LEVEL, AMBER_GREEN, 8'd0};
                default:        c = '{FULL_LEVEL, 8'd0, 8'd0};
            endcase
        end
        return c;
    endfunction

    // sin squared of a Q30 angle in the first quarter wave, Q0.16 result
    function automatic logic [15:0] envelope_level(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        term = x;
        sum  = x;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
        sum  = sum - term;
        sq = (sum * sum + (64'd1 << 43)) >> 44;
        if (sq > 64'd65535)
            sq = 64'd65535;
        return sq[15:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/led_breathe_flash_sequencer_unit.sv
// led_breathe_flash_sequencer_unit: top level with input item register and result register
// depends on lbfs_pkg, lbfs_flash and lbfs_target
`default_nettype none

// Drives one RGB LED from a stream of items: ticks of 10 ms, set-target items (off, solid,
// breathing) and flash requests. Every accepted item gives exactly one result with the colour
// shown after it and whether a flash is playing. An item goes into an input register, the
// next state and colour are formed in one pass of logic (rom lookup and three 8x16 multiplies
// for breathing) and land in the result register, so one item is taken every clock while the
// result is not stalled. Its result is offered from the result register once the item has moved
// on from the input register. The sin squared rom is built at elaboration from
// ENVELOPE_STEPS and needs no fill time after reset.

module led_breathe_flash_sequencer_unit #(
    parameter int ENVELOPE_STEPS = 200
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] operation,
    input  wire logic [1:0] target_mode,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic [2:0] flash_kind,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic            flash_busy
);
    import lbfs_pkg::*;

    logic        held_valid_reg, held_valid_next;
    item_t       held_item_reg;
    logic        result_valid_reg, result_valid_next;
    flash_view_t result_reg;

    logic        accept;
    logic        go;
    logic        result_free;
    logic        flash_playing;
    flash_view_t flash_next;
    colour_t     target_shown;

    assign result_free = !result_valid_reg || !result_stall;
    assign go          = held_valid_reg && result_free;
    assign item_stall  = held_valid_reg && !result_free;
    assign accept      = item_valid && !item_stall;

    assign held_valid_next   = accept ? 1'b1 : (go ? 1'b0 : held_valid_reg);
    assign result_valid_next = go ? 1'b1 : (result_free ? 1'b0 : result_valid_reg);

    lbfs_flash u_flash (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .item      (held_item_reg),
        .playing   (flash_playing),
        .view_next (flash_next)
    );

    lbfs_target #(
        .ENVELOPE_STEPS (ENVELOPE_STEPS)
    ) u_target (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .item          (held_item_reg),
        .flash_playing (flash_playing),
        .shown_next    (target_shown)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg   <= held_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_item_reg <= '{operation, target_mode, '{red_in, green_in, blue_in}, flash_kind};
        if (go)
        begin
            result_reg.busy   <= flash_next.busy;
            result_reg.colour <= flash_next.busy ? flash_next.colour : target_shown;
        end
    end

    assign result_valid = result_valid_reg;
    assign red_out      = result_reg.colour.red;
    assign green_out    = result_reg.colour.green;
    assign blue_out     = result_reg.colour.blue;
    assign flash_busy   = result_reg.busy;

    // an item moved into the result stage is offered next cycle
    assert property (@(posedge clk) disable iff (!rst_n) go |=> result_valid_reg)
        else $error("processed item not offered as a result");

    // a held item that cannot advance is neither lost nor altered
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid_reg && !go) |=> (held_valid_reg && $stable(held_item_reg)))
        else $error("held item lost or changed while blocked");

    // flash colours are only ever full or dark on red
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.busy) |->
            (result_reg.colour.red == 8'd0 || result_reg.colour.red == FULL_LEVEL))
        else $error("flash shows a red level outside its patterns");

endmodule

`default_nettype wire

// File: hw/rtl/lbfs_flash.sv
// lbfs_flash: flash pattern player with a one-deep latest-wins request queue
// uses lbfs_pkg for item codes and pattern tables
`default_nettype none

module lbfs_flash (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire lbfs_pkg::item_t      item,
    output logic                      playing,
    output lbfs_pkg::flash_view_t     view_next
);
    import lbfs_pkg::*;

    logic       playing_reg, playing_next;
    logic [2:0] kind_reg, kind_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] ticks_reg, ticks_next;
    logic       queued_valid_reg, queued_valid_next;
    logic [2:0] queued_kind_reg, queued_kind_next;

    logic [3:0] ticks_dec;
    logic [2:0] phase_inc;

    assign ticks_dec = (ticks_reg != 4'd0) ? ticks_reg - 4'd1 : ticks_reg;
    assign phase_inc = phase_reg + 3'd1;

    always_comb
    begin
        playing_next      = playing_reg;
        kind_next         = kind_reg;
        phase_next        = phase_reg;
        ticks_next        = ticks_reg;
        queued_valid_next = queued_valid_reg;
        queued_kind_next  = queued_kind_reg;
        if (go)
        begin
            case (item.operation)
                OP_TICK:
                begin
                    if (playing_reg)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == 4'd0)
                        begin
                            if (phase_inc >= phase_count(kind_reg))
                            begin
                                playing_next = 1'b0;
                                phase_next   = 3'd0;
                                if (queued_valid_reg)
                                begin
                                    playing_next      = 1'b1;
                                    kind_next         = queued_kind_reg;
                                    ticks_next        = phase_length(queued_kind_reg);
                                    queued_valid_next = 1'b0;
                                    queued_kind_next  = 3'd0;
                                end
                            end
                            else
                            begin
                                phase_next = phase_inc;
                                ticks_next = phase_length(kind_reg);
                            end
                        end
                    end
                end
                OP_FLASH:
                begin
                    if (item.flash_kind <= FLASH_WARNING)
                    begin
                        if (playing_reg)
                        begin
                            queued_valid_next = 1'b1;
                            queued_kind_next  = item.flash_kind;
                        end
                        else
                        begin
                            playing_next = 1'b1;
                            kind_next    = item.flash_kind;
                            phase_next   = 3'd0;
                            ticks_next   = phase_length(item.flash_kind);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg      <= 1'b0;
            kind_reg         <= 3'd0;
            phase_reg        <= 3'd0;
            ticks_reg        <= 4'd0;
            queued_valid_reg <= 1'b0;
            queued_kind_reg  <= 3'd0;
        end
        else
        begin
            playing_reg      <= playing_next;
            kind_reg         <= kind_next;
            phase_reg        <= phase_next;
            ticks_reg        <= ticks_next;
            queued_valid_reg <= queued_valid_next;
            queued_kind_reg  <= queued_kind_next;
        end
    end

    assign playing          = playing_reg;
    assign view_next.busy   = playing_next;
    assign view_next.colour = playing_next ? phase_colour(kind_next, phase_next) : '0;

endmodule

`default_nettype wire

// File: hw/rtl/lbfs_target.sv
// lbfs_target: target mode and colour, breathing envelope position and sin squared rom
// uses lbfs_pkg for item codes and the envelope function
`default_nettype none

module lbfs_target #(
    parameter int ENVELOPE_STEPS = 200
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 go,
    input  wire lbfs_pkg::item_t      item,
    input  wire logic                 flash_playing,
    output lbfs_pkg::colour_t         shown_next
);
    import lbfs_pkg::*;

    localparam int STEP_W = $clog2(ENVELOPE_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ENVELOPE_STEPS - 1);

    logic [15:0] envelope_rom [ENVELOPE_STEPS];

    for (genvar i = 0; i < ENVELOPE_STEPS; i++)
    begin : g_rom
        localparam int unsigned FOLDED =
            (2 * i > ENVELOPE_STEPS) ? ENVELOPE_STEPS - i : i;
        localparam logic [63:0] ANGLE = (PI_Q30 * 64'(FOLDED)) / 64'(ENVELOPE_STEPS);
        localparam logic [15:0] LEVEL = envelope_level(ANGLE);
        assign envelope_rom[i] = LEVEL;
    end

    logic [1:0]        mode_reg, mode_next;
    colour_t           colour_reg, colour_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [15:0] level;
    logic [23:0] red_prod;
    logic [23:0] green_prod;
    logic [23:0] blue_prod;

    always_comb
    begin
        mode_next   = mode_reg;
        colour_next = colour_reg;
        step_next   = step_reg;
        if (go)
        begin
            case (item.operation)
                OP_TICK:
                begin
                    if (!flash_playing && mode_reg == MODE_BREATHE)
                        step_next = (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
                end
                OP_SET_TARGET:
                begin
                    if (item.target_mode <= MODE_BREATHE)
                    begin
                        mode_next   = item.target_mode;
                        colour_next = item.colour;
                        if (item.target_mode != MODE_OFF && item.colour == '0)
                            colour_next = '{GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign level      = envelope_rom[step_next];
    assign red_prod   = {16'd0, colour_next.red} * {8'd0, level};
    assign green_prod = {16'd0, colour_next.green} * {8'd0, level};
    assign blue_prod  = {16'd0, colour_next.blue} * {8'd0, level};

    always_comb
    begin
        case (mode_next)
            MODE_SOLID:   shown_next = colour_next;
            MODE_BREATHE: shown_next = '{red_prod[23:16], green_prod[23:16], blue_prod[23:16]};
            default:      shown_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            colour_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            colour_reg <= colour_next;
            step_reg   <= step_next;
        end
    end

endmodule

`default_nettype wire
